[hw/rtl/lz4_block_decompressor_top_macros.svh]
// assertion macros for the lz4 block decompressor
`ifndef LZ4_BLOCK_DECOMPRESSOR_TOP_MACROS_SVH
`define LZ4_BLOCK_DECOMPRESSOR_TOP_MACROS_SVH

// concurrent check on clock, disabled in reset
`define LZ4D_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication form of the check above
`define LZ4D_ASSERT_IMPLIES(label, ante, cons, msg) \
   `LZ4D_ASSERT(label, (ante) |-> (cons), msg)

`endif

[hw/rtl/lz4d_pkg.sv]
package lz4d_pkg;

   localparam int HISTORY_BYTES = 65536;
   localparam int HIST_AW       = $clog2(HISTORY_BYTES);
   localparam int LENGTH_BITS   = 24;
   localparam int LIMIT_W       = 24;
   localparam int BYTE_W        = 8;
   localparam int NIBBLE_W      = 4;

   localparam logic [NIBBLE_W-1:0] NIBBLE_EXT = 4'hF;
   localparam logic [BYTE_W-1:0]   BYTE_EXT   = 8'hFF;
   localparam logic [NIBBLE_W:0]   MATCH_MIN  = 5'd4;

   typedef enum logic [1:0] {
      ACT_IDLE  = 2'd0,
      ACT_BYTE  = 2'd1,
      ACT_START = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_RUN      = 3'd0,
      ST_DONE     = 3'd1,
      ST_BADOFF   = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_TRUNC    = 3'd4,
      ST_LENOVF   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      PH_TOKEN    = 3'd0,
      PH_LITEXT   = 3'd1,
      PH_LITERALS = 3'd2,
      PH_OFFLO    = 3'd3,
      PH_OFFHI    = 3'd4,
      PH_MATCHEXT = 3'd5,
      PH_COPY     = 3'd6
   } phase_type;

endpackage

[hw/rtl/lz4d_channels.sv]
interface lz4d_req_if import lz4d_pkg::*; ();
   logic              valid;
   logic              ready;
   action_type        action;
   logic [BYTE_W-1:0] in_byte;
   logic              in_last;

   modport source (output valid, action, in_byte, in_last, input ready);
   modport sink   (input valid, action, in_byte, in_last, output ready);
endinterface

interface lz4d_rsp_if import lz4d_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              out_valid;
   logic [BYTE_W-1:0] out_byte;
   logic              byte_taken;
   status_type        status;

   modport source (output valid, out_valid, out_byte, byte_taken, status, input ready);
   modport sink   (input valid, out_valid, out_byte, byte_taken, status, output ready);
endinterface

[hw/rtl/lz4_block_decompressor_top.sv]
// LZ4 block decompressor.
// req_ch carries one request per transfer: an action (idle, compressed byte, start of
// block), the compressed byte and its last mark. rsp_ch returns exactly one response
// per request, in order: a decompressed byte with its valid flag, whether the
// compressed byte was consumed, and the block status after that request.
// While a match is copied, every request but a start yields one copied byte until the
// output limit is reached, and its compressed byte is not consumed; the source resends
// it. csr_wr_en/csr_wr_data set the output limit; the user must write it only while the
// block is idle, which the block itself does not enforce.
// A response passes the read stage (registered history read), then the output register.
// Throughput: one request per cycle while rsp_ch does not stall. Literals and copies
// share the single write port of the 64 KiB history memory; a copy that reads the byte
// being written in the same cycle takes it from the output register, not the memory.
// Reset clears the parser, counters, status and the pipeline, and sets the limit to
// its maximum; the history memory is not cleared.
// When rsp_ch stalls, the response holds in the output register, one more request is
// taken into an empty read stage, and then req_ch.ready drops until the stall clears.
module lz4_block_decompressor_top import lz4d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   lz4d_req_if.sink           req_ch,
   lz4d_rsp_if.source         rsp_ch
);

   localparam int SUM_W = LENGTH_BITS + 1;

   logic [BYTE_W-1:0] ring [HISTORY_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   phase_type            phase_ff, phase_in;
   status_type           status_ff, status_in;
   logic [HIST_AW-1:0]   wp_ff, wp_in;
   logic [LIMIT_W-1:0]   produced_ff, produced_in;
   logic [LENGTH_BITS-1:0] lit_rem_ff, lit_rem_in;
   logic [LENGTH_BITS-1:0] copy_rem_ff, copy_rem_in;
   logic [HIST_AW-1:0]   dist_ff, dist_in;
   logic [NIBBLE_W-1:0]  match_nib_ff, match_nib_in;
   logic                 ended_ff, ended_in;
   logic [LIMIT_W-1:0]   limit_ff;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_emit_ff;
   logic                 s1_copy_ff;
   logic                 s1_fwd_ff;
   logic                 s1_taken_ff;
   logic [BYTE_W-1:0]    s1_lit_ff;
   status_type           s1_status_ff;
   logic [HIST_AW-1:0]   s1_waddr_ff;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_emit_ff;
   logic                 out_taken_ff;
   logic [BYTE_W-1:0]    out_byte_ff;
   status_type           out_status_ff;

   logic                 req_xfer;
   logic                 s1_advance;
   logic                 run;
   logic                 can_emit;
   logic                 emit;
   logic                 taken;
   logic                 fwd;
   logic [HIST_AW-1:0]   rd_addr;
   logic [BYTE_W-1:0]    s1_byte;
   logic [LENGTH_BITS-1:0] lit_dec, copy_dec;
   logic [SUM_W-1:0]     lit_sum, copy_sum;
   logic [HIST_AW-1:0]   offset;

   assign s1_advance   = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   // outputs of the parser for the request at hand
   always_comb begin
      run      = req_xfer && (req_ch.action != ACT_START) && (status_ff == ST_RUN);
      can_emit = produced_ff < limit_ff;
      emit     = run && can_emit && ((phase_ff == PH_COPY) ||
                 ((req_ch.action == ACT_BYTE) && (phase_ff == PH_LITERALS)));
      taken    = run && (phase_ff != PH_COPY) && (req_ch.action == ACT_BYTE);
      rd_addr  = wp_ff - dist_ff;
      fwd      = s1_advance && s1_emit_ff && (s1_waddr_ff == rd_addr);
      s1_byte  = s1_copy_ff ? (s1_fwd_ff ? out_byte_ff : rd_data_ff) : s1_lit_ff;
   end

   // next state of the parser
   always_comb begin
      phase_in     = phase_ff;
      status_in    = status_ff;
      wp_in        = wp_ff;
      produced_in  = produced_ff;
      lit_rem_in   = lit_rem_ff;
      copy_rem_in  = copy_rem_ff;
      dist_in      = dist_ff;
      match_nib_in = match_nib_ff;
      ended_in     = ended_ff;
      lit_dec      = lit_rem_ff - LENGTH_BITS'(lit_rem_ff != '0);
      copy_dec     = copy_rem_ff - LENGTH_BITS'(copy_rem_ff != '0);
      lit_sum      = {1'b0, lit_rem_ff} + SUM_W'(req_ch.in_byte);
      copy_sum     = {1'b0, copy_rem_ff} + SUM_W'(req_ch.in_byte);
      offset       = {req_ch.in_byte, dist_ff[BYTE_W-1:0]};
      if (req_xfer) begin
         if (req_ch.action == ACT_START) begin
            phase_in     = PH_TOKEN;
            status_in    = ST_RUN;
            produced_in  = '0;
            lit_rem_in   = '0;
            copy_rem_in  = '0;
            dist_in      = '0;
            match_nib_in = '0;
            ended_in     = 1'b0;
         end else if (status_ff == ST_RUN) begin
            if (phase_ff == PH_COPY) begin
               if (!can_emit) begin
                  status_in = ST_OVERFLOW;
               end else begin
                  copy_rem_in = copy_dec;
                  if (copy_dec == '0) begin
                     if (ended_ff) status_in = ST_DONE;
                     else phase_in = PH_TOKEN;
                  end
               end
            end else if (req_ch.action == ACT_BYTE) begin
               unique case (phase_ff)
                  PH_TOKEN: begin
                     match_nib_in = req_ch.in_byte[NIBBLE_W-1:0];
                     lit_rem_in   = LENGTH_BITS'(req_ch.in_byte[BYTE_W-1:NIBBLE_W]);
                     if (req_ch.in_byte[BYTE_W-1:NIBBLE_W] == '0) begin
                        if (req_ch.in_last) status_in = ST_DONE;
                        else phase_in = PH_OFFLO;
                     end else if (req_ch.in_last) begin
                        status_in = ST_TRUNC;
                     end else if (req_ch.in_byte[BYTE_W-1:NIBBLE_W] == NIBBLE_EXT) begin
                        phase_in = PH_LITEXT;
                     end else begin
                        phase_in = PH_LITERALS;
                     end
                  end
                  PH_LITEXT: begin
                     if (lit_sum[LENGTH_BITS]) begin
                        status_in = ST_LENOVF;
                     end else begin
                        lit_rem_in = lit_sum[LENGTH_BITS-1:0];
                        if (req_ch.in_last) status_in = ST_TRUNC;
                        else if (req_ch.in_byte != BYTE_EXT) phase_in = PH_LITERALS;
                     end
                  end
                  PH_LITERALS: begin
                     if (!can_emit) begin
                        status_in = ST_OVERFLOW;
                     end else begin
                        lit_rem_in = lit_dec;
                        if (lit_dec == '0) begin
                           if (req_ch.in_last) status_in = ST_DONE;
                           else phase_in = PH_OFFLO;
                        end else if (req_ch.in_last) begin
                           status_in = ST_TRUNC;
                        end
                     end
                  end
                  PH_OFFLO: begin
                     dist_in = HIST_AW'(req_ch.in_byte);
                     if (req_ch.in_last) status_in = ST_TRUNC;
                     else phase_in = PH_OFFHI;
                  end
                  PH_OFFHI: begin
                     dist_in = offset;
                     if ((offset == '0) || (LIMIT_W'(offset) > produced_ff)) begin
                        status_in = ST_BADOFF;
                     end else begin
                        copy_rem_in = LENGTH_BITS'(match_nib_ff) + LENGTH_BITS'(MATCH_MIN);
                        if (match_nib_ff == NIBBLE_EXT) begin
                           if (req_ch.in_last) status_in = ST_TRUNC;
                           else phase_in = PH_MATCHEXT;
                        end else begin
                           phase_in = PH_COPY;
                           ended_in = req_ch.in_last;
                        end
                     end
                  end
                  PH_MATCHEXT: begin
                     if (copy_sum[LENGTH_BITS]) begin
                        status_in = ST_LENOVF;
                     end else begin
                        copy_rem_in = copy_sum[LENGTH_BITS-1:0];
                        if (req_ch.in_byte != BYTE_EXT) begin
                           phase_in = PH_COPY;
                           ended_in = req_ch.in_last;
                        end else if (req_ch.in_last) begin
                           status_in = ST_TRUNC;
                        end
                     end
                  end
                  PH_COPY: begin
                  end
               endcase
            end
         end
      end
      if (emit) begin
         wp_in       = wp_ff + 1'b1;
         produced_in = produced_ff + 1'b1;
      end
   end

   always_comb begin
      s1_valid_in  = req_xfer ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_advance ? 1'b1 : ((rsp_ch.valid && rsp_ch.ready) ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TOKEN;
         status_ff    <= ST_RUN;
         wp_ff        <= '0;
         produced_ff  <= '0;
         lit_rem_ff   <= '0;
         copy_rem_ff  <= '0;
         dist_ff      <= '0;
         match_nib_ff <= '0;
         ended_ff     <= 1'b0;
         limit_ff     <= '1;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         status_ff    <= status_in;
         wp_ff        <= wp_in;
         produced_ff  <= produced_in;
         lit_rem_ff   <= lit_rem_in;
         copy_rem_ff  <= copy_rem_in;
         dist_ff      <= dist_in;
         match_nib_ff <= match_nib_in;
         ended_ff     <= ended_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_emit_ff   <= emit;
         s1_copy_ff   <= (phase_ff == PH_COPY);
         s1_fwd_ff    <= fwd;
         s1_taken_ff  <= taken;
         s1_lit_ff    <= req_ch.in_byte;
         s1_status_ff <= status_in;
         s1_waddr_ff  <= wp_ff;
      end
   end

   // history ring
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rd_data_ff <= ring[rd_addr];
      end
      if (s1_advance && s1_emit_ff) begin
         ring[s1_waddr_ff] <= s1_byte;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_emit_ff   <= s1_emit_ff;
         out_taken_ff  <= s1_taken_ff;
         out_byte_ff   <= s1_emit_ff ? s1_byte : '0;
         out_status_ff <= s1_status_ff;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_valid  = out_emit_ff;
   assign rsp_ch.out_byte   = out_byte_ff;
   assign rsp_ch.byte_taken = out_taken_ff;
   assign rsp_ch.status     = out_status_ff;

endmodule

[hw/rtl/lz4d_checker.sv]
`include "lz4_block_decompressor_top_macros.svh"

module lz4d_checker import lz4d_pkg::*; (
   input logic        clock,
   input logic        reset,
   lz4d_req_if.sink   req_ch,
   lz4d_rsp_if.source rsp_ch
);

   // a stalled response keeps its payload
   `LZ4D_ASSERT(a_rsp_hold, rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.out_byte) && $stable(rsp_ch.status), "stalled response changed")

   // request side only stalls behind a stalled response
   `LZ4D_ASSERT_IMPLIES(a_req_stall, !req_ch.ready, rsp_ch.valid && !rsp_ch.ready, "request stalled without output stall")

   // every accepted request has a response pending once it has passed the read stage
   `LZ4D_ASSERT(a_rsp_latency, req_ch.valid && req_ch.ready |-> ##2 rsp_ch.valid, "response missing after request transfer")

   // a decompressed byte only comes with a running, finished or truncated block
   `LZ4D_ASSERT_IMPLIES(a_emit_status, rsp_ch.valid && rsp_ch.out_valid, (rsp_ch.status == ST_RUN) || (rsp_ch.status == ST_DONE) || (rsp_ch.status == ST_TRUNC), "byte emitted with error status")

endmodule

bind lz4_block_decompressor_top lz4d_checker u_lz4d_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);

[test/lz4d_checker.sv]
`timescale 1ns / 100ps
module lz4d_scoreboard import lz4d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   lz4d_req_if                req_ch,
   lz4d_rsp_if                rsp_ch,
   output int                 mismatches,
   output int                 outstanding,
   output int                 bytes_seen,
   output logic [7:0]         status_seen
);

   typedef struct packed {
      logic              out_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              byte_taken;
      status_type        status;
   } decoded_type;

   logic [BYTE_W-1:0]      ring [HISTORY_BYTES];
   logic [HIST_AW-1:0]     ring_ptr;
   logic [LIMIT_W-1:0]     out_limit;
   phase_type              phase;
   status_type             blk_status;
   logic [LIMIT_W-1:0]     produced;
   logic [LENGTH_BITS-1:0] lit_left;
   logic [LENGTH_BITS-1:0] copy_left;
   logic [HIST_AW-1:0]     distance;
   logic [NIBBLE_W-1:0]    match_nib;
   logic                   ended;
   decoded_type            expected_q[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      bytes_seen  = 0;
      status_seen = '0;
   end

   function automatic void open_block();
      phase      = PH_TOKEN;
      produced   = '0;
      lit_left   = '0;
      copy_left  = '0;
      distance   = '0;
      match_nib  = '0;
      ended      = 1'b0;
      blk_status = ST_RUN;
   endfunction

   // write one byte to the output and the ring unless the limit is reached
   function automatic bit put_out(logic [BYTE_W-1:0] v, inout decoded_type r);
      if (produced >= out_limit) begin
         blk_status = ST_OVERFLOW;
         return 1'b0;
      end
      ring[ring_ptr] = v;
      ring_ptr       = ring_ptr + 1'b1;
      produced       = produced + 1'b1;
      r.out_valid    = 1'b1;
      r.out_byte     = v;
      return 1'b1;
   endfunction

   function automatic decoded_type decode_request(action_type act, logic [BYTE_W-1:0] b,
                                                  logic last);
      decoded_type            r;
      logic [HIST_AW-1:0]     src;
      logic [LENGTH_BITS:0]   sum;
      r = '0;
      if (act == ACT_START) begin
         open_block();
      end else if (blk_status == ST_RUN) begin
         if (phase == PH_COPY) begin
            src = ring_ptr - distance;
            if (put_out(ring[src], r)) begin
               if (copy_left != 0) copy_left = copy_left - 1'b1;
               if (copy_left == 0) begin
                  if (ended) blk_status = ST_DONE;
                  else phase = PH_TOKEN;
               end
            end
         end else if (act == ACT_BYTE) begin
            r.byte_taken = 1'b1;
            case (phase)
               PH_TOKEN: begin
                  match_nib = b[3:0];
                  lit_left  = LENGTH_BITS'(b[7:4]);
                  if (lit_left == 0) begin
                     if (last) blk_status = ST_DONE;
                     else phase = PH_OFFLO;
                  end else if (last) begin
                     blk_status = ST_TRUNC;
                  end else if (b[7:4] == NIBBLE_EXT) begin
                     phase = PH_LITEXT;
                  end else begin
                     phase = PH_LITERALS;
                  end
               end
               PH_LITEXT: begin
                  sum = {1'b0, lit_left} + (LENGTH_BITS + 1)'(b);
                  if (sum[LENGTH_BITS]) begin
                     blk_status = ST_LENOVF;
                  end else begin
                     lit_left = sum[LENGTH_BITS-1:0];
                     if (last) blk_status = ST_TRUNC;
                     else if (b != BYTE_EXT) phase = PH_LITERALS;
                  end
               end
               PH_LITERALS: begin
                  if (put_out(b, r)) begin
                     if (lit_left != 0) lit_left = lit_left - 1'b1;
                     if (lit_left == 0) begin
                        if (last) blk_status = ST_DONE;
                        else phase = PH_OFFLO;
                     end else if (last) begin
                        blk_status = ST_TRUNC;
                     end
                  end
               end
               PH_OFFLO: begin
                  distance = HIST_AW'(b);
                  if (last) blk_status = ST_TRUNC;
                  else phase = PH_OFFHI;
               end
               PH_OFFHI: begin
                  distance = {b, distance[7:0]};
                  if (distance == 0 || LIMIT_W'(distance) > produced) begin
                     blk_status = ST_BADOFF;
                  end else begin
                     copy_left = LENGTH_BITS'(match_nib) + LENGTH_BITS'(MATCH_MIN);
                     if (match_nib == NIBBLE_EXT) begin
                        if (last) blk_status = ST_TRUNC;
                        else phase = PH_MATCHEXT;
                     end else begin
                        phase = PH_COPY;
                        ended = last;
                     end
                  end
               end
               PH_MATCHEXT: begin
                  sum = {1'b0, copy_left} + (LENGTH_BITS + 1)'(b);
                  if (sum[LENGTH_BITS]) begin
                     blk_status = ST_LENOVF;
                  end else begin
                     copy_left = sum[LENGTH_BITS-1:0];
                     if (b != BYTE_EXT) begin
                        phase = PH_COPY;
                        ended = last;
                     end else if (last) begin
                        blk_status = ST_TRUNC;
                     end
                  end
               end
               default: r.byte_taken = 1'b0;
            endcase
         end
      end
      r.status = blk_status;
      return r;
   endfunction

   task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      decoded_type want;
      if (reset) begin
         ring_ptr  = '0;
         out_limit = '1;
         open_block();
         expected_q.delete();
      end else begin
         if (csr_wr_en) out_limit = csr_wr_data;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               compare_field("out_valid", want.out_valid, rsp_ch.out_valid);
               compare_field("out_byte", want.out_byte, rsp_ch.out_byte);
               compare_field("byte_taken", want.byte_taken, rsp_ch.byte_taken);
               compare_field("status", want.status, rsp_ch.status);
            end
            if (rsp_ch.out_valid === 1'b1) bytes_seen++;
            status_seen[rsp_ch.status] = 1'b1;
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_q.push_back(decode_request(req_ch.action, req_ch.in_byte,
                                                req_ch.in_last));
         end
      end
      outstanding = expected_q.size();
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
module testbench import lz4d_pkg::*; ();

   localparam int         PERIOD      = 10;
   localparam int         CYCLE_LIMIT = 3000000;
   localparam action_type ACT_UNUSED  = action_type'(2'd3);

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   lz4d_req_if req_ch ();
   lz4d_rsp_if rsp_ch ();

   int         mismatches;
   int         outstanding;
   int         bytes_seen;
   logic [7:0] status_seen;

   bit gaps_on;
   bit stalls_on;
   bit want_hold;
   bit hold_done;
   int block_bytes;
   int items_sent;
   int target;

   always #(PERIOD / 2) clock = ~clock;

   lz4_block_decompressor_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   lz4d_scoreboard decode_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .bytes_seen  (bytes_seen),
      .status_seen (status_seen)
   );

   task automatic send_req(action_type act, logic [7:0] b, logic last);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.action  <= act;
      req_ch.in_byte <= b;
      req_ch.in_last <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] b, logic last);
      send_req(ACT_BYTE, b, last);
   endtask

   // requests that drive a copy; their bytes are offered but never taken
   task automatic pad_copy(int n);
      action_type act;
      repeat (n) begin
         case ($urandom_range(0, 2))
            0:       act = ACT_IDLE;
            1:       act = ACT_BYTE;
            default: act = ACT_UNUSED;
         endcase
         send_req(act, 8'($urandom), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic send_sequence(int lit_len, int match_len, bit final_seq, bit end_on_match);
      int         rest;
      int         span;
      int         offset;
      bit         lits_only;
      logic [3:0] lit_code;
      logic [3:0] match_code;
      lits_only = final_seq && !end_on_match;
      if (!lits_only && block_bytes == 0 && lit_len == 0) lit_len = 1;
      lit_code   = 4'(lit_len < 15 ? lit_len : 15);
      match_code = lits_only ? 4'($urandom_range(0, 15))
                             : 4'(match_len < 19 ? match_len - 4 : 15);
      send_byte({lit_code, match_code}, lits_only && lit_len == 0);
      if (lit_len >= 15) begin
         rest = lit_len - 15;
         while (rest >= 255) begin
            send_byte(BYTE_EXT, 1'b0);
            rest -= 255;
         end
         send_byte(8'(rest), 1'b0);
      end
      for (int i = 0; i < lit_len; i++) send_byte(8'($urandom), lits_only && i == lit_len - 1);
      block_bytes += lit_len;
      if (!lits_only) begin
         span = block_bytes < 65535 ? block_bytes : 65535;
         case ($urandom_range(0, 3))
            0:       offset = $urandom_range(1, span < 4 ? span : 4);
            1:       offset = span;
            default: offset = $urandom_range(1, span);
         endcase
         send_byte(offset[7:0], 1'b0);
         send_byte(offset[15:8], end_on_match && match_len < 19);
         if (match_len >= 19) begin
            rest = match_len - 19;
            while (rest >= 255) begin
               send_byte(BYTE_EXT, 1'b0);
               rest -= 255;
            end
            send_byte(8'(rest), end_on_match);
         end
         pad_copy(match_len);
         block_bytes += match_len;
      end
   endtask

   task automatic random_block();
      int nseq;
      int lit_len;
      int match_len;
      bit broken;
      send_req(ACT_START, 8'($urandom), 1'($urandom_range(0, 1)));
      block_bytes = 0;
      nseq   = $urandom_range(1, 4);
      broken = $urandom_range(0, 5) == 0;
      for (int s = 0; s < nseq; s++) begin
         if (broken && s == nseq - 1) begin
            repeat ($urandom_range(1, 12)) begin
               send_req(action_type'(2'($urandom_range(0, 3))), 8'($urandom),
                        $urandom_range(0, 5) == 0);
            end
         end else begin
            lit_len   = $urandom_range(0, 11) == 0 ? $urandom_range(15, 400)
                                                   : $urandom_range(0, 18);
            match_len = $urandom_range(0, 11) == 0 ? $urandom_range(19, 400)
                                                   : $urandom_range(4, 24);
            send_sequence(lit_len, match_len, s == nseq - 1,
                          s == nseq - 1 && $urandom_range(0, 1));
         end
      end
   endtask

   task automatic set_limit(logic [LIMIT_W-1:0] value);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_phase(int n);
      target = items_sent + n;
      while (items_sent < target) random_block();
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (want_hold && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.action  = ACT_IDLE;
      req_ch.in_byte = '0;
      req_ch.in_last = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      gaps_on        = 1'b1;
      stalls_on      = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty last sequence, then a byte offered to a finished block
      send_req(ACT_START, 8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // one literal, overlapping match at distance one, block ends on the match
      send_req(ACT_START, 8'hFF, 1'b1);
      send_byte(8'h10, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b1);
      pad_copy(4);
      // zero offset
      send_req(ACT_START, 8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      // offset beyond the data produced
      send_req(ACT_START, 8'h00, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h00, 1'b0);
      // token with literals marked last
      send_req(ACT_START, 8'h00, 1'b0);
      send_byte(8'h20, 1'b1);

      want_hold = 1'b1;
      random_phase(300);

      set_limit('0);
      random_phase(150);

      set_limit(LIMIT_W'($urandom_range(1, 200)));
      random_phase(350);

      set_limit('1);
      random_phase(250);

      set_limit(LIMIT_W'($urandom_range(1000, 100000)));
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      random_phase(200);

      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("checked %0d request transfers and %0d decompressed bytes over five limits",
               items_sent, bytes_seen);
      $display("status codes observed (one bit per code): %b", status_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
